/* rtl/core/u8fib_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8fib_pkg
// Shared types, constants and the Fibonacci weight table for the
// UTF-8 to Fibonacci code encoder.
// ----------------------------------------------------------------------------
package u8fib_pkg;

  // result status codes
  localparam logic [1:0] ST_BYTE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // largest legal code point
  localparam logic [20:0] CP_MAX = 21'd1114111;

  // number of Fibonacci weights, index of the largest one
  localparam int unsigned NUM_WEIGHTS = 30;
  localparam logic [4:0] TOP_IDX = 5'(NUM_WEIGHTS - 1);

  // controller to datapath commands
  typedef struct packed {
    logic cap;        // latch the input word
    logic dec_data;   // apply decode of a data byte
    logic walk;       // one greedy compare-subtract step
    logic append;     // merge code into pending bits
    logic put_err;    // load error result
    logic put_ok;     // load stream-finished result
    logic put_flush;  // load zero padded partial byte
    logic put_byte;   // load next full byte and drop it
    logic clear;      // return stream state to reset
  } u8fib_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic func;       // latched word is an end item
    logic err_seen;   // error seen in this stream
    logic cont_nz;    // sequence unfinished
    logic cnt_nz;     // pending bits present
    logic dec_fail;   // decode of latched byte fails
    logic dec_done;   // decode completes a code point
    logic walk_end;   // walk at smallest weight
    logic app_emit;   // append leaves a full byte
    logic emit_last;  // byte being emitted is the final one
    logic slot_free;  // output register can take a result
  } u8fib_sts_t;

  // Fibonacci weights, smallest first
  function automatic logic [20:0] fib_weight(input logic [4:0] idx);
    logic [20:0] w;
    unique case (idx)
      5'd0:  w = 21'd1;
      5'd1:  w = 21'd2;
      5'd2:  w = 21'd3;
      5'd3:  w = 21'd5;
      5'd4:  w = 21'd8;
      5'd5:  w = 21'd13;
      5'd6:  w = 21'd21;
      5'd7:  w = 21'd34;
      5'd8:  w = 21'd55;
      5'd9:  w = 21'd89;
      5'd10: w = 21'd144;
      5'd11: w = 21'd233;
      5'd12: w = 21'd377;
      5'd13: w = 21'd610;
      5'd14: w = 21'd987;
      5'd15: w = 21'd1597;
      5'd16: w = 21'd2584;
      5'd17: w = 21'd4181;
      5'd18: w = 21'd6765;
      5'd19: w = 21'd10946;
      5'd20: w = 21'd17711;
      5'd21: w = 21'd28657;
      5'd22: w = 21'd46368;
      5'd23: w = 21'd75025;
      5'd24: w = 21'd121393;
      5'd25: w = 21'd196418;
      5'd26: w = 21'd317811;
      5'd27: w = 21'd514229;
      5'd28: w = 21'd832040;
      5'd29: w = 21'd1346269;
      default: w = 21'h1FFFFF;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/u8fib_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8fib_ctrl
// Sequencer: takes one word at a time, steps decode, the Zeckendorf walk,
// the merge into pending bits and the byte emission.
// ----------------------------------------------------------------------------
module u8fib_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  u8fib_pkg::u8fib_sts_t  sts,
  output u8fib_pkg::u8fib_cmd_t  cmd
);
  import u8fib_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.slot_free) begin
          state_nxt = S_IDLE;
          if (sts.func) begin
            if (sts.err_seen || sts.cont_nz) begin
              cmd.put_err = 1'b1;
              cmd.clear   = 1'b1;
            end else if (sts.cnt_nz) begin
              cmd.put_flush = 1'b1;
              state_nxt     = S_FIN;
            end else begin
              cmd.put_ok = 1'b1;
              cmd.clear  = 1'b1;
            end
          end else if (!sts.err_seen) begin
            cmd.dec_data = 1'b1;
            if (sts.dec_fail) begin
              cmd.put_err = 1'b1;
            end else if (sts.dec_done) begin
              state_nxt = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_end) begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = sts.app_emit ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.put_byte = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (sts.slot_free) begin
          cmd.put_ok = 1'b1;
          cmd.clear  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/u8fib_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8fib_dp
// Datapath: input word register, UTF-8 assembly, greedy Fibonacci walk,
// pending bit buffer and the output register.
// ----------------------------------------------------------------------------
module u8fib_dp (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire  [7:0]             in_tdata,
  input  wire                    in_tuser,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [7:0]             out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast,
  input  u8fib_pkg::u8fib_cmd_t  cmd,
  output u8fib_pkg::u8fib_sts_t  sts
);
  import u8fib_pkg::*;

  // latched input word
  logic [7:0]  byte_r;
  logic        func_r;

  // stream state
  logic [20:0] accum_r,   accum_nxt;
  logic [1:0]  cont_r,    cont_nxt;
  logic        err_r,     err_nxt;
  logic [37:0] pend_r,    pend_nxt;
  logic [5:0]  count_r,   count_nxt;

  // walk registers
  logic [20:0] val_r,     val_nxt;
  logic [4:0]  idx_r,     idx_nxt;
  logic [30:0] code_r,    code_nxt;
  logic [4:0]  len_r,     len_nxt;
  logic        found_r,   found_nxt;

  // output register
  logic        ovld_r,    ovld_nxt;
  logic [7:0]  obyte_r,   obyte_nxt;
  logic [1:0]  ostat_r,   ostat_nxt;
  logic        olast_r,   olast_nxt;

  // decode of latched byte
  logic [20:0] dec_acc;
  logic [1:0]  dec_cont;
  logic        dec_bad;
  logic        dec_fin;
  logic        dec_big;
  logic [20:0] weight;
  logic        hit;
  logic [5:0]  count_app;

  always_comb begin
    dec_acc  = accum_r;
    dec_cont = cont_r;
    dec_bad  = 1'b0;
    dec_fin  = 1'b0;
    if (cont_r == 2'd0) begin
      priority if (!byte_r[7]) begin
        dec_acc = {13'd0, byte_r};
        dec_fin = 1'b1;
      end else if (byte_r[7:5] == 3'b110) begin
        dec_acc  = {16'd0, byte_r[4:0]};
        dec_cont = 2'd1;
      end else if (byte_r[7:4] == 4'b1110) begin
        dec_acc  = {17'd0, byte_r[3:0]};
        dec_cont = 2'd2;
      end else if (byte_r[7:3] == 5'b11110) begin
        dec_acc  = {18'd0, byte_r[2:0]};
        dec_cont = 2'd3;
      end else begin
        dec_bad = 1'b1;
      end
    end else begin
      if (byte_r[7:6] != 2'b10) begin
        dec_bad = 1'b1;
      end
      dec_acc  = {accum_r[14:0], byte_r[5:0]};
      dec_cont = cont_r - 2'd1;
      dec_fin  = (cont_r == 2'd1);
    end
    dec_big = dec_acc > CP_MAX;
  end

  assign weight    = fib_weight(idx_r);
  assign hit       = val_r >= weight;
  assign count_app = count_r + {1'b0, len_r};

  // status to controller
  assign sts.func      = func_r;
  assign sts.err_seen  = err_r;
  assign sts.cont_nz   = (cont_r != 2'd0);
  assign sts.cnt_nz    = (count_r != 6'd0);
  assign sts.dec_fail  = dec_bad || (dec_fin && dec_big);
  assign sts.dec_done  = dec_fin && !dec_bad && !dec_big;
  assign sts.walk_end  = (idx_r == 5'd0);
  assign sts.app_emit  = (count_app >= 6'd8);
  assign sts.emit_last = (count_r < 6'd16);
  assign sts.slot_free = !ovld_r || out_tready;

  // stream state and walk update
  always_comb begin
    accum_nxt = accum_r;
    cont_nxt  = cont_r;
    err_nxt   = err_r;
    pend_nxt  = pend_r;
    count_nxt = count_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    code_nxt  = code_r;
    len_nxt   = len_r;
    found_nxt = found_r;
    if (cmd.dec_data) begin
      if (sts.dec_fail) begin
        err_nxt   = 1'b1;
        cont_nxt  = 2'd0;
        accum_nxt = '0;
      end else if (dec_fin) begin
        accum_nxt = '0;
        cont_nxt  = 2'd0;
        val_nxt   = dec_acc + 21'd1;
        idx_nxt   = TOP_IDX;
        code_nxt  = '0;
        found_nxt = 1'b0;
      end else begin
        accum_nxt = dec_acc;
        cont_nxt  = dec_cont;
      end
    end
    if (cmd.walk) begin
      if (hit) begin
        val_nxt          = val_r - weight;
        code_nxt[idx_r]  = 1'b1;
        if (!found_r) begin
          code_nxt[idx_r + 5'd1] = 1'b1;
          len_nxt                = idx_r + 5'd2;
          found_nxt              = 1'b1;
        end
      end
      idx_nxt = idx_r - 5'd1;
    end
    if (cmd.append) begin
      pend_nxt  = pend_r | ({7'd0, code_r} << count_r);
      count_nxt = count_app;
    end
    if (cmd.put_byte) begin
      pend_nxt  = pend_r >> 8;
      count_nxt = count_r - 6'd8;
    end
    if (cmd.clear) begin
      accum_nxt = '0;
      cont_nxt  = 2'd0;
      err_nxt   = 1'b0;
      pend_nxt  = '0;
      count_nxt = '0;
    end
  end

  // output register load
  always_comb begin
    ovld_nxt  = ovld_r && !out_tready;
    obyte_nxt = obyte_r;
    ostat_nxt = ostat_r;
    olast_nxt = olast_r;
    priority if (cmd.put_err) begin
      ovld_nxt  = 1'b1;
      obyte_nxt = 8'd0;
      ostat_nxt = ST_ERR;
      olast_nxt = 1'b1;
    end else if (cmd.put_ok) begin
      ovld_nxt  = 1'b1;
      obyte_nxt = 8'd0;
      ostat_nxt = ST_DONE;
      olast_nxt = 1'b1;
    end else if (cmd.put_flush) begin
      ovld_nxt  = 1'b1;
      obyte_nxt = pend_r[7:0];
      ostat_nxt = ST_BYTE;
      olast_nxt = 1'b0;
    end else if (cmd.put_byte) begin
      ovld_nxt  = 1'b1;
      obyte_nxt = pend_r[7:0];
      ostat_nxt = ST_BYTE;
      olast_nxt = sts.emit_last;
    end else begin
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      cont_r  <= 2'd0;
      err_r   <= 1'b0;
      pend_r  <= '0;
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      accum_r <= accum_nxt;
      cont_r  <= cont_nxt;
      err_r   <= err_nxt;
      pend_r  <= pend_nxt;
      count_r <= count_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      byte_r <= in_tdata;
      func_r <= in_tuser;
    end
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    code_r  <= code_nxt;
    len_r   <= len_nxt;
    found_r <= found_nxt;
    obyte_r <= obyte_nxt;
    ostat_r <= ostat_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = obyte_r;
  assign out_tuser  = ostat_r;
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

/* rtl/core/utf8_to_fibonacci_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_fibonacci_encoder
// Decodes a UTF-8 byte stream and packs the Fibonacci code of each code
// point plus one into bytes, least significant bit first.
// ----------------------------------------------------------------------------
// One word is handled at a time. A data byte that does not complete a code
// point is only decoded; one that completes a code point is decoded, then put
// through a greedy compare-subtract over the Fibonacci weights, largest first
// (one weight per cycle), then its code is merged into the pending bits and
// each full byte (up to 4) is emitted. An end word (tuser high) gives one or
// two results. Results stall in a single output register; the next word is
// taken once the current one is done. Malformed input gives a status 2 result
// and data words are dropped until the end word.
module utf8_to_fibonacci_encoder (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] in_byte
  input  wire        in_tuser,   // [0] func: 0 data byte, 1 end of stream
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] status: 0 byte, 1 finished, 2 error
  output logic       out_tlast   // last result of the input word
);
  import u8fib_pkg::*;

  u8fib_cmd_t cmd;
  u8fib_sts_t sts;

  // sequencer
  u8fib_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  u8fib_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire
